// ----- rtl/core/ils_pkg.sv -----
// Shared types, codes and constants for the indexed list store.
`default_nettype none
package ils_pkg;

	localparam int CAPACITY_DEF = 64;
	// Wide enough for any index or count up to the largest supported capacity
	localparam int IDX_W = 11;

	localparam logic [2:0] FN_APPEND = 3'd0;
	localparam logic [2:0] FN_INSERT = 3'd1;
	localparam logic [2:0] FN_DELETE = 3'd2;
	localparam logic [2:0] FN_FIND   = 3'd3;
	localparam logic [2:0] FN_GET    = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_LOAD,
		CELL_SHIFT
	} cell_op_t;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	typedef struct packed {
		cell_op_t          op;
		logic [IDX_W-1:0]  pos;
		logic [IDX_W-1:0]  cnt;
		logic              find;
		logic [31:0]       value;
	} ils_ctrl_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] data;
	} ils_scan_t;

endpackage
`default_nettype wire

// ----- rtl/core/ils_if.sv -----
// Request and response channel interfaces of the indexed list store.
`default_nettype none
interface ils_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        func;
	logic [5:0]        position;
	logic signed [31:0] value;

	modport source(output valid, func, position, value, input ready);
	modport sink(input valid, func, position, value, output ready);
endinterface

interface ils_rsp_if;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic signed [31:0] data;
	logic [6:0]        count;

	modport source(output valid, status, data, count, input ready);
	modport sink(input valid, status, data, count, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ils_cell.sv -----
// One list slot: holds an entry and a scan register, shifts with its neighbours.
`default_nettype none
module ils_cell
	import ils_pkg::*;
(
	input  wire logic             clk,
	input  wire ils_ctrl_t        ctrl,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic [31:0]      lower_entry,
	input  wire logic [31:0]      upper_entry,
	input  wire ils_scan_t        upper_scan,
	output      logic [31:0]      entry,
	output      ils_scan_t        scan
);

	logic [31:0] entry_q;
	ils_scan_t   scan_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (idx == ctrl.pos)
					entry_q <= ctrl.value;
				else if (idx > ctrl.pos)
					entry_q <= lower_entry;
			end
			CELL_DELETE: begin
				if (idx >= ctrl.pos)
					entry_q <= upper_entry;
			end
			CELL_LOAD: begin
				if (ctrl.find) begin
					scan_q.hit  <= (entry_q == ctrl.value) && (idx < ctrl.cnt);
					scan_q.data <= 32'(idx);
				end else begin
					scan_q.hit  <= (idx == ctrl.pos);
					scan_q.data <= entry_q;
				end
			end
			CELL_SHIFT: begin
				// a hit stays put, so the lowest hit reaches slot zero first
				if (!scan_q.hit)
					scan_q <= upper_scan;
			end
			default: ;
		endcase
	end

	assign entry = entry_q;
	assign scan  = scan_q;

endmodule
`default_nettype wire

// ----- rtl/core/indexed_list_store_top.sv -----
// Top level of the indexed list store: request decode, scan control and result register.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------
//  req     | in  | func, position, value
//  rsp     | out | status, data, count
//
// Append, insert, delete, bad codes and out-of-range requests are answered
// directly from decode. Get and find scan down the cell chain; find reports
// not-found once the scan has passed the current count of entries.
// One request is in flight at a time; a new beat is taken while the last
// result is being taken. rsp stalls hold the result register and block req.
// Reset clears the count and control; entry contents are not cleared.
`default_nettype none
module indexed_list_store_top
	import ils_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ils_req_if.sink   req,
	ils_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	state_t         state_q, state_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  step_q, step_d;
	logic           rsp_valid_q;
	logic [1:0]     status_q;
	logic [31:0]    data_q;

	logic             load_res;
	logic [1:0]       res_status;
	logic [31:0]      res_data;
	logic             slot_free, acc, full;
	logic [IDX_W-1:0] pos_x, cnt_x;
	ils_ctrl_t        ctrl;

	logic [31:0] entry_w [CAPACITY];
	ils_scan_t   scan_w  [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] lower, upper;
		ils_scan_t   upper_s;
		if (i == 0) begin : g_lo
			assign lower = entry_w[i];
		end else begin : g_lo
			assign lower = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi
			assign upper   = entry_w[i];
			assign upper_s = '0;
		end else begin : g_hi
			assign upper   = entry_w[i+1];
			assign upper_s = scan_w[i+1];
		end
		ils_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.idx         (IDX_W'(i)),
			.lower_entry (lower),
			.upper_entry (upper),
			.upper_scan  (upper_s),
			.entry       (entry_w[i]),
			.scan        (scan_w[i])
		);
	end

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign acc       = req.valid && req.ready;
	assign pos_x     = IDX_W'(req.position);
	assign cnt_x     = IDX_W'(count_q);
	assign full      = count_q >= CW'(CAPACITY);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		step_d     = step_q;
		load_res   = 1'b0;
		res_status = ST_OK;
		res_data   = '0;
		ctrl.op    = CELL_HOLD;
		ctrl.pos   = pos_x;
		ctrl.cnt   = cnt_x;
		ctrl.find  = (req.func == FN_FIND);
		ctrl.value = req.value;

		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.func)
						FN_APPEND: begin
							load_res = 1'b1;
							if (full) begin
								res_status = ST_FULL;
							end else begin
								ctrl.op  = CELL_INSERT;
								ctrl.pos = cnt_x;
								count_d  = count_q + CW'(1);
							end
						end
						FN_INSERT: begin
							load_res = 1'b1;
							if (pos_x > cnt_x) begin
								res_status = ST_RANGE;
							end else if (full) begin
								res_status = ST_FULL;
							end else begin
								ctrl.op = CELL_INSERT;
								count_d = count_q + CW'(1);
							end
						end
						FN_DELETE: begin
							load_res = 1'b1;
							if (pos_x >= cnt_x) begin
								res_status = ST_RANGE;
							end else begin
								ctrl.op = CELL_DELETE;
								count_d = count_q - CW'(1);
							end
						end
						FN_FIND: begin
							ctrl.op = CELL_LOAD;
							step_d  = '0;
							state_d = S_SCAN;
						end
						FN_GET: begin
							if (pos_x >= cnt_x) begin
								load_res   = 1'b1;
								res_status = ST_RANGE;
							end else begin
								ctrl.op = CELL_LOAD;
								step_d  = '0;
								state_d = S_SCAN;
							end
						end
						default: load_res = 1'b1;
					endcase
				end
			end
			S_SCAN: begin
				if (slot_free) begin
					if (scan_w[0].hit) begin
						load_res = 1'b1;
						res_data = scan_w[0].data;
						state_d  = S_IDLE;
					end else if (IDX_W'(step_q) + IDX_W'(1) >= cnt_x) begin
						load_res   = 1'b1;
						res_status = ST_NOTFOUND;
						state_d    = S_IDLE;
					end else begin
						ctrl.op = CELL_SHIFT;
						step_d  = step_q + CW'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			step_q  <= step_d;
			if (load_res)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			status_q <= res_status;
			data_q   <= res_data;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.data   = data_q;
	// count register changes only together with a new result
	assign rsp.count  = 7'(count_q);

endmodule
`default_nettype wire
